[design/tkeu_pkg.sv]
// shared types, codes and the encoder step table for the tick unit
package tkeu_pkg;

  // item operation codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_READ_EVENT = 3'd1;
  localparam logic [2:0] OP_PEEK_EVENT = 3'd2;
  localparam logic [2:0] OP_LOAD_DELAY = 3'd3;
  localparam logic [2:0] OP_LOAD_BEEP  = 3'd4;

  // event codes
  localparam logic [3:0] EV_NONE  = 4'd0;
  localparam logic [3:0] EV_PLUS  = 4'd1;
  localparam logic [3:0] EV_MINUS = 4'd2;
  localparam logic [3:0] EV_RIGHT = 4'd3;
  localparam logic [3:0] EV_LEFT  = 4'd4;
  localparam logic [3:0] EV_KEY1  = 4'd5;
  localparam logic [3:0] EV_KEY2  = 4'd6;
  localparam logic [3:0] EV_KEY3  = 4'd7;
  localparam logic [3:0] EV_KEY4  = 4'd8;

  // encoder step directions
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_FWD  = 2'd1;
  localparam logic [1:0] STEP_BACK = 2'd2;

  // raw key register layout
  localparam int unsigned ENC_X_LSB = 12;
  localparam int unsigned ENC_Y_LSB = 14;
  localparam logic [15:0] KEY_MASK  = 16'h000f;

  // encoder and key scan state carried from tick to tick
  typedef struct packed {
    logic       primed;
    logic [1:0] enc_x;
    logic [1:0] enc_y;
    logic [3:0] keys;
    logic [3:0] event_code;
  } scan_state_t;

  // step table indexed by {old, new}
  function automatic logic [1:0] step_dir(input logic [3:0] idx);
    logic [1:0] dir;
    unique case (idx)
      4'b0111, 4'b1100: dir = STEP_FWD;
      4'b0011, 4'b0100: dir = STEP_BACK;
      default:          dir = STEP_NONE;
    endcase
    return dir;
  endfunction

endpackage

[design/tkeu_if.sv]
// handshake channels for request items and result items

interface tkeu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] keys_raw;
  logic [31:0] load_value;

  modport source (output valid, output op, output keys_raw, output load_value, input ready);
  modport sink   (input valid, input op, input keys_raw, input load_value, output ready);
endinterface

interface tkeu_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_code;
  logic [31:0] tick_total;
  logic [31:0] delay_left;
  logic [31:0] beep_left;
  logic        beep_stop;

  modport source (output valid, output event_code, output tick_total, output delay_left,
                  output beep_left, output beep_stop, input ready);
  modport sink   (input valid, input event_code, input tick_total, input delay_left,
                  input beep_left, input beep_stop, output ready);
endinterface

[design/tkeu_event_dec.sv]
// encoder and key event decoder for one tick
module tkeu_event_dec (
  input  logic [15:0]          keys_raw,
  input  tkeu_pkg::scan_state_t prev,
  output tkeu_pkg::scan_state_t next
);
  import tkeu_pkg::*;

  logic [1:0] ex;
  logic [1:0] ey;
  logic [3:0] k;
  logic [1:0] old_x;
  logic [1:0] old_y;
  logic [3:0] old_k;
  logic [1:0] dir_x;
  logic [1:0] dir_y;
  logic [3:0] ev;

  // split the raw key register
  assign ex = keys_raw[ENC_X_LSB +: 2];
  assign ey = keys_raw[ENC_Y_LSB +: 2];
  assign k  = 4'(keys_raw & KEY_MASK);

  // first tick only captures, so old state equals the new sample
  assign old_x = prev.primed ? prev.enc_x : ex;
  assign old_y = prev.primed ? prev.enc_y : ey;
  assign old_k = prev.primed ? prev.keys  : k;

  assign dir_x = step_dir({old_x, ex});
  assign dir_y = step_dir({old_y, ey});

  // x, then y, then keys; later source wins; a release of all keys keeps the event
  always_comb begin
    ev = prev.event_code;
    if (dir_x == STEP_FWD)       ev = EV_PLUS;
    else if (dir_x == STEP_BACK) ev = EV_MINUS;
    if (dir_y == STEP_FWD)       ev = EV_RIGHT;
    else if (dir_y == STEP_BACK) ev = EV_LEFT;
    if (old_k != k && k != '0) begin
      priority if (k[3]) ev = EV_KEY4;
      else if (k[2])     ev = EV_KEY3;
      else if (k[1])     ev = EV_KEY2;
      else if (k[0])     ev = EV_KEY1;
    end
  end

  assign next.primed     = 1'b1;
  assign next.enc_x      = ex;
  assign next.enc_y      = ey;
  assign next.keys       = k;
  assign next.event_code = ev;

endmodule

[design/tick_encoder_key_event_unit.sv]
// tick unit top level: counters, beep timer, encoder and key events
// an accepted item passes the input register, then the result register, held there until taken
// one item per cycle while results are taken; the state update is one pass between both registers
// a waiting result holds the result register; one more item enters, then the input stalls
// reset (rst, synchronous): counters, scan state and stored event clear, both stages empty
// no clearing pass: the block takes items in the first cycle after reset
module tick_encoder_key_event_unit (
  input logic         clk,
  input logic         rst,
  tkeu_req_if.sink    req,
  tkeu_rsp_if.source  rsp
);
  import tkeu_pkg::*;

  // input stage
  logic        s1_valid;
  logic [2:0]  s1_op;
  logic [15:0] s1_keys;
  logic [31:0] s1_load;
  logic        advance;

  // block state
  logic [31:0] tick_count;
  logic [31:0] delay_count;
  logic [31:0] beep_count;
  scan_state_t scan;

  logic [31:0] tick_count_next;
  logic [31:0] delay_count_next;
  logic [31:0] beep_count_next;
  scan_state_t scan_next;
  scan_state_t scan_dec;
  logic [3:0]  ev_out;
  logic        stop;

  // result stage
  logic        out_valid;
  logic [3:0]  out_event;
  logic [31:0] out_ticks;
  logic [31:0] out_delay;
  logic [31:0] out_beep;
  logic        out_stop;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1_op   <= req.op;
      s1_keys <= req.keys_raw;
      s1_load <= req.load_value;
    end
  end

  tkeu_event_dec u_dec (
    .keys_raw (s1_keys),
    .prev     (scan),
    .next     (scan_dec)
  );

  // per item state update
  always_comb begin
    tick_count_next  = tick_count;
    delay_count_next = delay_count;
    beep_count_next  = beep_count;
    scan_next        = scan;
    ev_out           = scan.event_code;
    stop             = 1'b0;
    unique case (s1_op)
      OP_TICK: begin
        tick_count_next = tick_count + 32'd1;
        if (delay_count != '0) delay_count_next = delay_count - 32'd1;
        if (beep_count != '0) begin
          beep_count_next = beep_count - 32'd1;
          stop            = (beep_count == 32'd1);
        end
        scan_next = scan_dec;
        ev_out    = scan_dec.event_code;
      end
      OP_READ_EVENT: begin
        scan_next.event_code = EV_NONE;
      end
      OP_LOAD_DELAY: begin
        delay_count_next = s1_load;
      end
      OP_LOAD_BEEP: begin
        beep_count_next = s1_load;
      end
      default: begin
        // peek and unused codes leave the state alone
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      delay_count <= '0;
      beep_count  <= '0;
      scan        <= '0;
    end else if (advance) begin
      tick_count  <= tick_count_next;
      delay_count <= delay_count_next;
      beep_count  <= beep_count_next;
      scan        <= scan_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_event <= ev_out;
      out_ticks <= tick_count_next;
      out_delay <= delay_count_next;
      out_beep  <= beep_count_next;
      out_stop  <= stop;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.event_code = out_event;
  assign rsp.tick_total = out_ticks;
  assign rsp.delay_left = out_delay;
  assign rsp.beep_left  = out_beep;
  assign rsp.beep_stop  = out_stop;

endmodule

[design/tkeu_checker.sv]
// port level checks for the tick unit, bound to the top level
module tkeu_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  rsp_event_code,
  input logic [31:0] rsp_beep_left,
  input logic        rsp_beep_stop
);
  import tkeu_pkg::*;

  // result stays offered until taken
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  // input side stalls only behind a held result
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled while result path was free");

  // a beep stop pulse leaves the timer at zero
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_beep_stop |-> rsp_beep_left == '0)
    else $error("beep stop with beep count left");

  // event codes stay within the defined set
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_event_code <= EV_KEY4)
    else $error("event code out of range");

  // reset empties the result stage
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind tick_encoder_key_event_unit tkeu_checker u_tkeu_checker (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_event_code (rsp.event_code),
  .rsp_beep_left  (rsp.beep_left),
  .rsp_beep_stop  (rsp.beep_stop)
);
